// File: hdl/snf_pkg.sv
// Shared types and opcode constants for the serial NOR flash target.
`default_nettype none
package snf_pkg;

  // Bus event codes carried in req_type.
  localparam logic [2:0] REQ_SEL   = 3'd0;
  localparam logic [2:0] REQ_DESEL = 3'd1;
  localparam logic [2:0] REQ_WRB   = 3'd2;
  localparam logic [2:0] REQ_RDB   = 3'd3;
  localparam logic [2:0] REQ_CHIP  = 3'd4;

  // Decoder command codes.
  localparam logic [2:0] CMD_IDLE   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_FAST   = 3'd2;
  localparam logic [2:0] CMD_PROG   = 3'd3;
  localparam logic [2:0] CMD_ERASE  = 3'd4;
  localparam logic [2:0] CMD_STATUS = 3'd5;
  localparam logic [2:0] CMD_ID     = 3'd6;
  localparam logic [2:0] CMD_SKIP   = 3'd7;

  // Opcodes.
  localparam logic [7:0] OP_READ   = 8'h03;
  localparam logic [7:0] OP_FAST   = 8'h0B;
  localparam logic [7:0] OP_PROG   = 8'h02;
  localparam logic [7:0] OP_SERASE = 8'h20;
  localparam logic [7:0] OP_STATUS = 8'h05;
  localparam logic [7:0] OP_ID     = 8'h9F;
  localparam logic [7:0] OP_WREN   = 8'h06;
  localparam logic [7:0] OP_WRDI   = 8'h04;
  localparam logic [7:0] OP_RSTEN  = 8'h66;
  localparam logic [7:0] OP_RST    = 8'h99;

  localparam logic [7:0] ID_MFR  = 8'hEF;
  localparam logic [7:0] ID_TYPE = 8'h70;
  localparam logic [7:0] ID_CAP  = 8'h18;
  localparam logic [7:0] ERASED  = 8'hFF;

  localparam logic [1:0] ST_WIP  = 2'b01;
  localparam logic [1:0] ST_WEL  = 2'b10;
  localparam logic [1:0] ADDR_LEN = 2'd3;

  // Byte address of the flash size register on the configuration port.
  localparam logic [1:0] ADDR_FLASH_BYTES = 2'd0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       err;
  } rsp_t;

  // Requests from the decoder to the array.
  typedef struct packed {
    logic        rd_en;
    logic [23:0] rd_addr;
    logic        wr_en;
    logic [23:0] wr_addr;
    logic [7:0]  wr_data;
    logic        fill_go;
    logic [24:0] fill_from;
    logic [24:0] fill_to;
  } arr_req_t;

endpackage
`default_nettype wire

// File: hdl/snf_array.sv
// Flash byte array with a registered read port and an erase fill engine.
`default_nettype none
module snf_array #(
  parameter int MEM_BYTES = 65536
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire snf_pkg::arr_req_t ctl,
  output logic [7:0]           q,
  output logic                 filling
);
  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [24:0] fptr;
  logic [24:0] fend;

  // After reset the whole array is swept to the erased value.
  always_ff @(posedge clk) begin
    if (rst) begin
      filling <= 1'b1;
      fptr    <= '0;
      fend    <= 25'(MEM_BYTES);
    end else if (filling) begin
      fptr <= fptr + 25'd1;
      if (fptr + 25'd1 == fend) begin
        filling <= 1'b0;
      end
    end else if (ctl.fill_go) begin
      filling <= 1'b1;
      fptr    <= ctl.fill_from;
      fend    <= ctl.fill_to;
    end
  end

  always_ff @(posedge clk) begin
    if (filling) begin
      mem[fptr[AW-1:0]] <= snf_pkg::ERASED;
    end else if (ctl.wr_en) begin
      mem[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      q <= mem[ctl.rd_addr[AW-1:0]];
    end
  end
endmodule
`default_nettype wire

// File: hdl/spi_nor_flash_device.sv
// Serial NOR flash target: command decoder, status and configuration port.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------
//  request   | start / busy           | req  (req_type, wr_byte)
//  result    | done, one cycle        | rsp  (rd_byte, err)
//  config    | APB psel/penable/pwrite| flash_bytes at address 0
//
// Most beats give their result in the cycle after acceptance. An array read
// is answered from S_RD, after the array port returns the byte; a program byte
// keeps busy high through S_PRG (read then write of the array port). After
// reset the whole array is swept to 0xFF with busy high; a sector erase sweeps
// up to SECTOR_BYTES bytes and a chip erase up to the limit, starting in the
// cycle of the result of the beat that started them. Results cannot stall.
`default_nettype none
module spi_nor_flash_device #(
  parameter int MEM_BYTES    = 65536,
  parameter int SECTOR_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire snf_pkg::req_t req,
  output logic               done,
  output snf_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [1:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_PRG  = 3'b100
  } state_t;

  localparam logic [24:0] MEM_LIM  = 25'(MEM_BYTES);
  localparam logic [23:0] SEC_MASK = ~24'(SECTOR_BYTES - 1);
  localparam logic [24:0] SEC_SIZE = 25'(SECTOR_BYTES);

  state_t state, state_next;
  logic [16:0] flash_bytes;
  logic [1:0]  status_bits, status_bits_next;
  logic [2:0]  cmd, cmd_next;
  logic        selected, selected_next;
  logic [1:0]  addr_count, addr_count_next;
  logic        dummy_seen, dummy_seen_next;
  logic [23:0] addr_shift, addr_shift_next;
  logic [23:0] cursor, cursor_next;
  logic [1:0]  id_index, id_index_next;
  logic        reset_armed, reset_armed_next;
  logic [23:0] prg_addr, prg_addr_next;
  logic [7:0]  prg_byte, prg_byte_next;
  logic        done_next;
  snf_pkg::rsp_t rsp_next;

  snf_pkg::arr_req_t ctl;
  logic [7:0]  q;
  logic        filling;
  logic        accept;
  logic [24:0] lim;
  logic [24:0] sbase, send;
  logic [23:0] shift_new;

  snf_array #(.MEM_BYTES(MEM_BYTES)) u_array (
    .clk(clk), .rst(rst), .ctl(ctl), .q(q), .filling(filling)
  );

  assign pready = 1'b1;
  assign prdata = {15'd0, flash_bytes};
  assign busy   = (state != S_IDLE) || filling;
  assign accept = start && !busy;
  assign lim    = ({8'd0, flash_bytes} < MEM_LIM) ? {8'd0, flash_bytes} : MEM_LIM;
  assign sbase  = {1'b0, addr_shift & SEC_MASK};
  assign send   = sbase + SEC_SIZE;
  assign shift_new = {addr_shift[15:0], req.wr_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_bytes <= 17'h10000;
    end else if (psel && penable && pwrite && paddr == snf_pkg::ADDR_FLASH_BYTES) begin
      flash_bytes <= pwdata[16:0];
    end
  end

  always_comb begin
    state_next       = state;
    status_bits_next = status_bits;
    cmd_next         = cmd;
    selected_next    = selected;
    addr_count_next  = addr_count;
    dummy_seen_next  = dummy_seen;
    addr_shift_next  = addr_shift;
    cursor_next      = cursor;
    id_index_next    = id_index;
    reset_armed_next = reset_armed;
    prg_addr_next    = prg_addr;
    prg_byte_next    = prg_byte;
    done_next        = 1'b0;
    rsp_next         = '{rd_byte: snf_pkg::ERASED, err: 1'b0};
    ctl              = '0;
    ctl.rd_addr      = cursor;
    ctl.wr_addr      = prg_addr;
    ctl.wr_data      = q & prg_byte;

    case (state)
      S_RD: begin
        done_next        = 1'b1;
        rsp_next.rd_byte = q;
        state_next       = S_IDLE;
      end
      S_PRG: begin
        ctl.wr_en  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        if (accept) begin
          done_next = 1'b1;
          case (req.req_type)
            snf_pkg::REQ_SEL: begin
              selected_next   = 1'b1;
              cmd_next        = snf_pkg::CMD_IDLE;
              addr_count_next = '0;
              dummy_seen_next = 1'b0;
              addr_shift_next = '0;
              cursor_next     = '0;
              id_index_next   = '0;
            end
            snf_pkg::REQ_DESEL: begin
              if (selected) begin
                if (cmd == snf_pkg::CMD_PROG) begin
                  status_bits_next = '0;
                end else if (cmd == snf_pkg::CMD_ERASE) begin
                  status_bits_next = status_bits & ~snf_pkg::ST_WIP;
                  if (addr_count == snf_pkg::ADDR_LEN) begin
                    status_bits_next = '0;
                    if (sbase < lim) begin
                      ctl.fill_go   = 1'b1;
                      ctl.fill_from = sbase;
                      ctl.fill_to   = (send < lim) ? send : lim;
                    end
                  end
                end
                selected_next   = 1'b0;
                cmd_next        = snf_pkg::CMD_IDLE;
                addr_count_next = '0;
                dummy_seen_next = 1'b0;
                addr_shift_next = '0;
                cursor_next     = '0;
                id_index_next   = '0;
              end
            end
            snf_pkg::REQ_WRB: begin
              if (!selected) begin
                rsp_next.err = 1'b1;
              end else if (cmd == snf_pkg::CMD_IDLE) begin
                reset_armed_next = 1'b0;
                cmd_next         = snf_pkg::CMD_SKIP;
                case (req.wr_byte)
                  snf_pkg::OP_READ:   cmd_next = snf_pkg::CMD_READ;
                  snf_pkg::OP_FAST:   cmd_next = snf_pkg::CMD_FAST;
                  snf_pkg::OP_PROG: begin
                    cmd_next         = snf_pkg::CMD_PROG;
                    status_bits_next = status_bits | snf_pkg::ST_WIP;
                  end
                  snf_pkg::OP_SERASE: begin
                    cmd_next         = snf_pkg::CMD_ERASE;
                    status_bits_next = status_bits | snf_pkg::ST_WIP;
                  end
                  snf_pkg::OP_STATUS: cmd_next = snf_pkg::CMD_STATUS;
                  snf_pkg::OP_ID:     cmd_next = snf_pkg::CMD_ID;
                  snf_pkg::OP_WREN:   status_bits_next = status_bits | snf_pkg::ST_WEL;
                  snf_pkg::OP_WRDI:   status_bits_next = status_bits & ~snf_pkg::ST_WEL;
                  snf_pkg::OP_RSTEN:  reset_armed_next = 1'b1;
                  snf_pkg::OP_RST: begin
                    if (reset_armed) begin
                      status_bits_next = '0;
                    end
                  end
                  default: begin
                  end
                endcase
              end else if (cmd == snf_pkg::CMD_READ || cmd == snf_pkg::CMD_FAST ||
                           cmd == snf_pkg::CMD_PROG || cmd == snf_pkg::CMD_ERASE) begin
                if (addr_count < snf_pkg::ADDR_LEN) begin
                  addr_shift_next = shift_new;
                  addr_count_next = addr_count + 2'd1;
                  if (addr_count == snf_pkg::ADDR_LEN - 2'd1) begin
                    cursor_next = shift_new;
                  end
                end else if (cmd == snf_pkg::CMD_FAST && !dummy_seen) begin
                  dummy_seen_next = 1'b1;
                end else if (cmd == snf_pkg::CMD_PROG && {1'b0, cursor} < lim) begin
                  // Read the old byte now; the ANDed value goes back next cycle.
                  ctl.rd_en     = 1'b1;
                  prg_addr_next = cursor;
                  prg_byte_next = req.wr_byte;
                  cursor_next   = cursor + 24'd1;
                  state_next    = S_PRG;
                end
              end
            end
            snf_pkg::REQ_RDB: begin
              if (!selected) begin
                rsp_next.err = 1'b1;
              end else if (cmd == snf_pkg::CMD_READ || cmd == snf_pkg::CMD_FAST) begin
                if (addr_count == snf_pkg::ADDR_LEN &&
                    (cmd == snf_pkg::CMD_READ || dummy_seen) &&
                    {1'b0, cursor} < lim) begin
                  ctl.rd_en   = 1'b1;
                  cursor_next = cursor + 24'd1;
                  done_next   = 1'b0;
                  state_next  = S_RD;
                end
              end else if (cmd == snf_pkg::CMD_STATUS) begin
                rsp_next.rd_byte = {6'd0, status_bits};
              end else if (cmd == snf_pkg::CMD_ID) begin
                if (id_index != 2'd3) begin
                  id_index_next = id_index + 2'd1;
                end
                case (id_index)
                  2'd0:    rsp_next.rd_byte = snf_pkg::ID_MFR;
                  2'd1:    rsp_next.rd_byte = snf_pkg::ID_TYPE;
                  2'd2:    rsp_next.rd_byte = snf_pkg::ID_CAP;
                  default: rsp_next.rd_byte = snf_pkg::ERASED;
                endcase
              end
            end
            snf_pkg::REQ_CHIP: begin
              if (lim != '0) begin
                ctl.fill_go   = 1'b1;
                ctl.fill_from = '0;
                ctl.fill_to   = lim;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      status_bits <= '0;
      cmd         <= snf_pkg::CMD_IDLE;
      selected    <= 1'b0;
      addr_count  <= '0;
      dummy_seen  <= 1'b0;
      addr_shift  <= '0;
      cursor      <= '0;
      id_index    <= '0;
      reset_armed <= 1'b0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      status_bits <= status_bits_next;
      cmd         <= cmd_next;
      selected    <= selected_next;
      addr_count  <= addr_count_next;
      dummy_seen  <= dummy_seen_next;
      addr_shift  <= addr_shift_next;
      cursor      <= cursor_next;
      id_index    <= id_index_next;
      reset_armed <= reset_armed_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    prg_addr <= prg_addr_next;
    prg_byte <= prg_byte_next;
    rsp      <= rsp_next;
  end
endmodule
`default_nettype wire

// File: hdl/snf_checker.sv
// Port-level checks on the flash target and their bind.
`default_nettype none
module snf_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire snf_pkg::rsp_t rsp
);
  // The clearing pass keeps the block busy straight after reset.
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // An accepted beat is either still at work or answered in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat neither busy nor answered");

  // Error results come straight from the beat before.
  a_err_timing: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.err) |-> $past(start && !busy))
    else $error("error result without a beat in the cycle before");

  // An error result always carries the idle byte.
  a_err_byte: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.err) |-> (rsp.rd_byte == snf_pkg::ERASED))
    else $error("error result with data");
endmodule

bind spi_nor_flash_device snf_checker u_snf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the serial NOR flash target.
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int MEM_SIZE    = 65536;
  localparam int SECTOR_SIZE = 4096;
  localparam int WATCHDOG    = 400000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  snf_pkg::req_t req = '0;
  logic          done;
  snf_pkg::rsp_t rsp;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [1:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  spi_nor_flash_device i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the flash target.
  logic [7:0]  shadow_mem [MEM_SIZE];
  logic [16:0] sh_flash_bytes;
  logic [1:0]  sh_status;
  logic [2:0]  sh_cmd;
  logic        sh_sel;
  logic [1:0]  sh_acnt;
  logic        sh_dummy;
  logic [23:0] sh_ashift;
  logic [23:0] sh_cursor;
  logic [1:0]  sh_id_idx;
  logic        sh_armed;

  snf_pkg::req_t pending_beats[$];
  snf_pkg::rsp_t awaited_rsp[$];
  int   n_issued = 0;
  int   n_taken = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   idle_cnt = 0;
  bit   no_idle = 1'b0;
  bit   hold_send = 1'b0;

  function automatic int flash_limit();
    return (sh_flash_bytes < MEM_SIZE) ? int'(sh_flash_bytes) : MEM_SIZE;
  endfunction

  function automatic void fill_ff(int from, int upto);
    for (int a = from; a < upto; a++) shadow_mem[a] = snf_pkg::ERASED;
  endfunction

  function automatic void clear_decoder();
    sh_cmd = snf_pkg::CMD_IDLE;
    sh_acnt = '0;
    sh_dummy = 1'b0;
    sh_ashift = '0;
    sh_cursor = '0;
    sh_id_idx = '0;
  endfunction

  function automatic void decode_op(logic [7:0] op);
    logic was_armed;
    was_armed = sh_armed;
    sh_armed = 1'b0;
    sh_cmd = snf_pkg::CMD_SKIP;
    case (op)
      snf_pkg::OP_READ:   sh_cmd = snf_pkg::CMD_READ;
      snf_pkg::OP_FAST:   sh_cmd = snf_pkg::CMD_FAST;
      snf_pkg::OP_PROG: begin
        sh_cmd = snf_pkg::CMD_PROG;
        sh_status |= snf_pkg::ST_WIP;
      end
      snf_pkg::OP_SERASE: begin
        sh_cmd = snf_pkg::CMD_ERASE;
        sh_status |= snf_pkg::ST_WIP;
      end
      snf_pkg::OP_STATUS: sh_cmd = snf_pkg::CMD_STATUS;
      snf_pkg::OP_ID:     sh_cmd = snf_pkg::CMD_ID;
      snf_pkg::OP_WREN:   sh_status |= snf_pkg::ST_WEL;
      snf_pkg::OP_WRDI:   sh_status &= ~snf_pkg::ST_WEL;
      snf_pkg::OP_RSTEN:  sh_armed = 1'b1;
      snf_pkg::OP_RST: begin
        if (was_armed) sh_status = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic void shift_in(logic [7:0] b);
    if (sh_cmd == snf_pkg::CMD_IDLE) begin
      decode_op(b);
    end else if (sh_cmd inside {snf_pkg::CMD_READ, snf_pkg::CMD_FAST,
                                snf_pkg::CMD_PROG, snf_pkg::CMD_ERASE}) begin
      if (sh_acnt < snf_pkg::ADDR_LEN) begin
        sh_ashift = {sh_ashift[15:0], b};
        sh_acnt++;
        if (sh_acnt == snf_pkg::ADDR_LEN) sh_cursor = sh_ashift;
      end else if (sh_cmd == snf_pkg::CMD_FAST && !sh_dummy) begin
        sh_dummy = 1'b1;
      end else if (sh_cmd == snf_pkg::CMD_PROG && int'(sh_cursor) < flash_limit()) begin
        shadow_mem[sh_cursor] &= b;
        sh_cursor++;
      end
    end
  endfunction

  function automatic logic [7:0] shift_out();
    logic [1:0] i;
    if (sh_cmd == snf_pkg::CMD_READ || sh_cmd == snf_pkg::CMD_FAST) begin
      if (sh_acnt < snf_pkg::ADDR_LEN || (sh_cmd == snf_pkg::CMD_FAST && !sh_dummy))
        return snf_pkg::ERASED;
      if (int'(sh_cursor) < flash_limit()) begin
        i = 2'd0;
        sh_cursor++;
        return shadow_mem[sh_cursor - 24'd1];
      end
      return snf_pkg::ERASED;
    end
    if (sh_cmd == snf_pkg::CMD_STATUS) return {6'd0, sh_status};
    if (sh_cmd == snf_pkg::CMD_ID) begin
      i = sh_id_idx;
      if (sh_id_idx < 2'd3) sh_id_idx++;
      case (i)
        2'd0: return snf_pkg::ID_MFR;
        2'd1: return snf_pkg::ID_TYPE;
        2'd2: return snf_pkg::ID_CAP;
        default: return snf_pkg::ERASED;
      endcase
    end
    return snf_pkg::ERASED;
  endfunction

  function automatic void release_chip();
    int base;
    int lim;
    if (!sh_sel) return;
    if (sh_cmd == snf_pkg::CMD_PROG) begin
      sh_status &= ~(snf_pkg::ST_WIP | snf_pkg::ST_WEL);
    end else if (sh_cmd == snf_pkg::CMD_ERASE) begin
      sh_status &= ~snf_pkg::ST_WIP;
      if (sh_acnt == snf_pkg::ADDR_LEN) begin
        lim = flash_limit();
        base = int'(sh_ashift) - (int'(sh_ashift) % SECTOR_SIZE);
        if (base < lim) fill_ff(base, (base + SECTOR_SIZE < lim) ? base + SECTOR_SIZE : lim);
        sh_status &= ~snf_pkg::ST_WEL;
      end
    end
    sh_sel = 1'b0;
    clear_decoder();
  endfunction

  function automatic snf_pkg::rsp_t flash_response(snf_pkg::req_t r);
    snf_pkg::rsp_t o;
    o.rd_byte = snf_pkg::ERASED;
    o.err = 1'b0;
    case (r.req_type)
      snf_pkg::REQ_SEL: begin
        sh_sel = 1'b1;
        clear_decoder();
      end
      snf_pkg::REQ_DESEL: release_chip();
      snf_pkg::REQ_WRB: begin
        if (!sh_sel) o.err = 1'b1;
        else shift_in(r.wr_byte);
      end
      snf_pkg::REQ_RDB: begin
        if (!sh_sel) o.err = 1'b1;
        else o.rd_byte = shift_out();
      end
      snf_pkg::REQ_CHIP: fill_ff(0, flash_limit());
      default: ;
    endcase
    return o;
  endfunction

  // Driver: a beat stays on the bus until it is taken.
  always @(negedge clk) begin
    logic          nxt_start;
    snf_pkg::req_t nxt_req;
    nxt_start = 1'b0;
    nxt_req = req;
    if (!rst) begin
      if (start && n_taken != n_issued) begin
        nxt_start = 1'b1;
      end else if (idle_cnt > 0) begin
        idle_cnt--;
      end else if (pending_beats.size() > 0 && !hold_send) begin
        nxt_req = pending_beats.pop_front();
        nxt_start = 1'b1;
        n_issued++;
        if (!no_idle && $urandom_range(0, 5) == 0) idle_cnt = $urandom_range(1, 5);
      end
    end
    start <= nxt_start;
    req <= nxt_req;
  end

  // Monitor and checker.
  always @(posedge clk) begin
    snf_pkg::rsp_t exp_rsp;
    int            quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (done) begin
        quiet = 0;
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected result rd_byte=%h err=%b", $time, rsp.rd_byte, rsp.err);
          n_errors++;
        end else begin
          exp_rsp = awaited_rsp.pop_front();
          n_checked++;
          if (rsp.rd_byte !== exp_rsp.rd_byte)
            begin
            $display("%0t: rd_byte mismatch expected %h actual %h", $time,
                     exp_rsp.rd_byte, rsp.rd_byte);
            n_errors++;
          end
          if (rsp.err !== exp_rsp.err) begin
            $display("%0t: err mismatch expected %b actual %b", $time, exp_rsp.err, rsp.err);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        quiet = 0;
        awaited_rsp.push_back(flash_response(req));
        n_taken++;
      end
      if (quiet >= WATCHDOG) begin
        $display("%0t: timeout with %0d results outstanding", $time, awaited_rsp.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus helpers.
  int cur_limit = MEM_SIZE;
  int n_built = 0;

  task automatic add(logic [2:0] t, logic [7:0] b);
    snf_pkg::req_t r;
    r.req_type = t;
    r.wr_byte = b;
    pending_beats.push_back(r);
    n_built++;
  endtask

  task automatic add_addr(logic [23:0] a, int nbytes);
    for (int k = 0; k < nbytes; k++) add(snf_pkg::REQ_WRB, a[23 - 8 * k -: 8]);
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && n_taken == n_issued && awaited_rsp.size() == 0);
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_flash_bytes(logic [16:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= snf_pkg::ADDR_FLASH_BYTES;
    pwdata <= {15'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sh_flash_bytes = v;
    cur_limit = (v < MEM_SIZE) ? int'(v) : MEM_SIZE;
  endtask

  function automatic logic [23:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return 24'($urandom());
      1: return 24'(cur_limit - 1);
      2: return 24'(cur_limit);
      default: return 24'($urandom_range(0, cur_limit + 4));
    endcase
  endfunction

  task automatic random_txn();
    int kind;
    int n;
    int alen;
    kind = $urandom_range(0, 99);
    alen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
    n = $urandom_range(1, 8);
    if (kind < 25) begin
      add(snf_pkg::REQ_SEL, 8'($urandom()));
      add(snf_pkg::REQ_WRB, snf_pkg::OP_READ);
      add_addr(pick_addr(), alen);
      for (int k = 0; k < n; k++)
        add(($urandom_range(0, 5) == 0) ? snf_pkg::REQ_WRB : snf_pkg::REQ_RDB,
            8'($urandom()));
      add(snf_pkg::REQ_DESEL, 8'($urandom()));
    end else if (kind < 35) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_FAST);
      add_addr(pick_addr(), alen);
      if ($urandom_range(0, 3) != 0) add(snf_pkg::REQ_WRB, 8'($urandom()));
      for (int k = 0; k < n; k++) add(snf_pkg::REQ_RDB, 8'($urandom()));
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 60) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_WREN);
      add(snf_pkg::REQ_DESEL, 8'h00);
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_PROG);
      add_addr(pick_addr(), alen);
      for (int k = 0; k < n; k++)
        add(($urandom_range(0, 7) == 0) ? snf_pkg::REQ_RDB : snf_pkg::REQ_WRB,
            8'($urandom()));
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 63) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_SERASE);
      add_addr(pick_addr(), alen);
      add(snf_pkg::REQ_RDB, 8'h00);
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 70) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_STATUS);
      for (int k = 0; k < n; k++)
        add($urandom_range(0, 3) == 0 ? snf_pkg::REQ_WRB : snf_pkg::REQ_RDB,
            8'($urandom()));
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 75) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_ID);
      for (int k = 0; k < n; k++) add(snf_pkg::REQ_RDB, 8'h00);
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 80) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, $urandom_range(0, 1) ? snf_pkg::OP_WREN : snf_pkg::OP_WRDI);
      add(snf_pkg::REQ_RDB, 8'h00);
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 86) begin
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, snf_pkg::OP_RSTEN);
      if ($urandom_range(0, 1)) add(snf_pkg::REQ_DESEL, 8'h00);
      add(snf_pkg::REQ_SEL, 8'h00);
      add(snf_pkg::REQ_WRB, $urandom_range(0, 3) ? snf_pkg::OP_RST : 8'($urandom()));
      add(snf_pkg::REQ_DESEL, 8'h00);
    end else if (kind < 88) begin
      // A whole-array erase is slow at large sizes, so it is kept to small ones.
      if (cur_limit <= 8192) add(snf_pkg::REQ_CHIP, 8'($urandom()));
    end else begin
      for (int k = 0; k < n; k++) add(3'($urandom_range(0, 7)), 8'($urandom()));
    end
  endtask

  task automatic random_phase(logic [16:0] fb, int beats, bit quiet_bus);
    int stop_at;
    drain();
    write_flash_bytes(fb);
    no_idle = quiet_bus;
    stop_at = n_built + beats;
    while (n_built < stop_at) random_txn();
  endtask

  initial begin
    sh_flash_bytes = 17'd65536;
    sh_status = '0;
    sh_sel = 1'b0;
    sh_armed = 1'b0;
    clear_decoder();
    fill_ff(0, MEM_SIZE);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: bytes while deselected, ID, program and read back, fast read
    // across the end of the array, unused codes, chip erase.
    add(snf_pkg::REQ_WRB, 8'hFF);
    add(snf_pkg::REQ_RDB, 8'h00);
    add(snf_pkg::REQ_DESEL, 8'h00);
    add(snf_pkg::REQ_SEL, 8'h00);
    add(snf_pkg::REQ_WRB, snf_pkg::OP_ID);
    repeat (4) add(snf_pkg::REQ_RDB, 8'h00);
    add(snf_pkg::REQ_SEL, 8'h00);
    add(snf_pkg::REQ_WRB, snf_pkg::OP_PROG);
    add_addr(24'h00FFFF, 3);
    add(snf_pkg::REQ_WRB, 8'h00);
    add(snf_pkg::REQ_WRB, 8'h5A);
    add(snf_pkg::REQ_DESEL, 8'h00);
    add(snf_pkg::REQ_SEL, 8'h00);
    add(snf_pkg::REQ_WRB, snf_pkg::OP_FAST);
    add_addr(24'h00FFFF, 3);
    add(snf_pkg::REQ_RDB, 8'h00);
    add(snf_pkg::REQ_WRB, 8'hAA);
    repeat (2) add(snf_pkg::REQ_RDB, 8'h00);
    add(snf_pkg::REQ_DESEL, 8'h00);
    add(3'd5, 8'h00);
    add(3'd7, 8'hFF);
    add(snf_pkg::REQ_CHIP, 8'h00);
    drain();

    random_phase(17'd1, 120, 1'b0);
    random_phase(17'd300, 150, 1'b0);
    random_phase(17'd65536, 150, 1'b0);
    random_phase(17'd5000, 150, 1'b0);
    // Hold the bus until everything is back, then the final phase runs flat out.
    random_phase(17'd4096, 60, 1'b0);
    hold_send = 1'b1;
    wait (n_taken == n_issued && awaited_rsp.size() == 0);
    repeat (3) @(posedge clk);
    hold_send = 1'b0;
    random_phase(17'd700, 130, 1'b1);
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d beats, %0d results checked, flash sizes 1 to 65536 bytes,",
             n_taken, n_checked);
    $display("covering read, fast read, program, erase, status, ID and reset sequences.");
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
